// File: src/arsu_pkg.sv
package arsu_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned IN_IDX_W  = 10;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FACTOR_W  = 16;
  localparam int unsigned PROD_W    = WORD_W + FACTOR_W;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned STEP_W    = 4;

  // Configuration port geometry: three registers on a 32-bit data bus at byte addresses 0, 4 and 8.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_INCREASE = 2'd0,
    REG_DECREASE = 2'd1,
    REG_START    = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  localparam logic [FACTOR_W-1:0] INCREASE_RST = 16'd18022;
  localparam logic [FACTOR_W-1:0] DECREASE_RST = 16'd11469;
  localparam logic [WORD_W-1:0]   START_RST    = 32'd167772;

  // Half of one output LSB in the Q10.38 product, for round half up.
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (FRAC_SHIFT - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_INIT  = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] old_weight;
    logic [WORD_W-1:0] prev_change;
    logic [WORD_W-1:0] rate;
  } entry_t;

  // Rounds a rate-times-factor product back to Q8.24 and saturates at all ones.
  function automatic logic [WORD_W-1:0] round_sat(input logic [PROD_W-1:0] prod);
    logic [PROD_W:0]                   sum;
    logic [PROD_W-FRAC_SHIFT:0]        shifted;
    sum     = {1'b0, prod} + ROUND_HALF;
    shifted = sum[PROD_W:FRAC_SHIFT];
    if (|shifted[PROD_W-FRAC_SHIFT:WORD_W]) begin
      return '1;
    end
    return shifted[WORD_W-1:0];
  endfunction

  // Weight difference saturated to signed 32 bits.
  function automatic logic signed [WORD_W-1:0] sat_diff(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] d;
    d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (d[WORD_W] != d[WORD_W-1]) begin
      return d[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end
    return d[WORD_W-1:0];
  endfunction

endpackage

// File: src/adaptive_rate_sign_update_top.sv
// Channel        Direction  Handshake                       Payload
// input          in         start / busy                    in_weight_index, in_weight_value,
//                                                           in_first_epoch
// result         out        out_valid (one-cycle strobe)    out_new_rate, out_weight_change,
//                                                           out_rate_grew
// configuration  in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// An accepted item passes through S_READ, S_INIT, S_MUL and S_WRITE with busy high before the next
// is taken; when NUM_WEIGHTS is below 1024 and not a power of two, S_MOD reduces the index first.
// The per-weight memory has one read and one write port and the 32x16 multiplier is shared by
// the start-rate scaling and the rate update, so one transaction owns both until its write-back.
// After reset the block sweeps the memory once to clear the valid flags, with busy high
// throughout; configuration writes are taken during that pass.
// The result is shown for one cycle and the receiver cannot stall it.

module adaptive_rate_sign_update_top #(
  parameter int unsigned NUM_WEIGHTS = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Input transaction.
  input  logic                                     start,
  output logic                                     busy,
  input  logic [arsu_pkg::IN_IDX_W-1:0]            in_weight_index,
  input  logic signed [arsu_pkg::WORD_W-1:0]       in_weight_value,
  input  logic                                     in_first_epoch,
  // Result transaction.
  output logic                                     out_valid,
  output logic [arsu_pkg::WORD_W-1:0]              out_new_rate,
  output logic signed [arsu_pkg::WORD_W-1:0]       out_weight_change,
  output logic                                     out_rate_grew,
  // Configuration port.
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [arsu_pkg::CFG_ADDR_W-1:0]          paddr,
  input  logic [arsu_pkg::CFG_DATA_W-1:0]          pwdata,
  output logic [arsu_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  import arsu_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_WEIGHTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WEIGHTS - 1);
  // The index port already wraps at 1024 and a power of two only needs truncation, so the
  // reciprocal reduction runs only for other sizes below 1024.
  localparam bit NEED_MOD = (NUM_WEIGHTS < (1 << IN_IDX_W)) &&
                            ((NUM_WEIGHTS & (NUM_WEIGHTS - 1)) != 0);
  localparam int unsigned MOD_W = 2 * IN_IDX_W;
  localparam int unsigned MOD_PROD_W = IN_IDX_W + MOD_W;
  // Reciprocal of NUM_WEIGHTS scaled by 2^MOD_W and rounded up. The quotient it gives is
  // exact for every 10-bit index, since the rounding error stays below one part in 1024.
  localparam logic [MOD_W-1:0] MOD_RECIP =
    MOD_W'(((1 << MOD_W) + NUM_WEIGHTS - 1) / NUM_WEIGHTS);
  localparam logic [IN_IDX_W-1:0] MOD_BASE = IN_IDX_W'(NUM_WEIGHTS);

  // Configuration registers.
  logic [FACTOR_W-1:0] increase_r;
  logic [FACTOR_W-1:0] decrease_r;
  logic [WORD_W-1:0]   start_rate_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      increase_r   <= INCREASE_RST;
      decrease_r   <= DECREASE_RST;
      start_rate_r <= START_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_INCREASE: increase_r   <= pwdata[FACTOR_W-1:0];
        REG_DECREASE: decrease_r   <= pwdata[FACTOR_W-1:0];
        REG_START:    start_rate_r <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_INCREASE: prdata = CFG_DATA_W'(increase_r);
      REG_DECREASE: prdata = CFG_DATA_W'(decrease_r);
      REG_START:    prdata = start_rate_r;
      default:      prdata = '0;
    endcase
  end

  // Control and transaction registers.
  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [IN_IDX_W-1:0]       red_r, red_nxt;
  logic [IN_IDX_W-1:0]       quo_r, quo_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic signed [WORD_W-1:0]  weight_r, weight_nxt;
  logic                      first_r, first_nxt;
  logic [WORD_W-1:0]         rate_sel_r, rate_sel_nxt;
  logic [FACTOR_W-1:0]       factor_sel_r, factor_sel_nxt;
  logic signed [WORD_W-1:0]  diff_r, diff_nxt;
  logic                      grow_r, grow_nxt;
  logic [PROD_W-1:0]         product_r, product_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]         out_rate_r, out_rate_nxt;
  logic signed [WORD_W-1:0]  out_change_r, out_change_nxt;
  logic                      out_grew_r, out_grew_nxt;

  // Per-weight memory: valid flag, old weight, previous change and rate in one word.
  entry_t                    entry_mem_r [NUM_WEIGHTS];
  entry_t                    rd_q_r;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  entry_t                    mem_wdata;
  logic                      rd_en;
  logic [IDX_W-1:0]          idx;

  // Scratch values of the update.
  logic [MOD_PROD_W-1:0]     quo_prod;
  logic [MOD_W-1:0]          mod_sub;
  logic [WORD_W-1:0]         init_rate;
  logic signed [WORD_W-1:0]  prev;
  logic signed [WORD_W-1:0]  diff_calc;
  logic                      grow_calc;
  logic [WORD_W-1:0]         mul_a;
  logic [FACTOR_W-1:0]       mul_b;

  assign idx      = IDX_W'(red_r);
  assign quo_prod = MOD_PROD_W'(red_r) * MOD_PROD_W'(MOD_RECIP);
  assign mod_sub  = MOD_W'(quo_r) * MOD_W'(MOD_BASE);
  assign busy     = (state_r != S_IDLE);

  // The shared multiplier scales the start rate while the memory read is in flight and
  // applies the chosen factor in S_MUL, after S_INIT has registered the choice.
  always_comb begin
    if (state_r == S_READ) begin
      mul_a = start_rate_r;
      mul_b = increase_r;
    end else begin
      mul_a = rate_sel_r;
      mul_b = factor_sel_r;
    end
    product_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // An entry that was never written reads as the scaled start rate with no previous change.
  always_comb begin
    init_rate = round_sat(product_r);
    prev      = rd_q_r.valid ? $signed(rd_q_r.prev_change) : '0;
    diff_calc = first_r ? '0 : sat_diff(weight_r, $signed(rd_q_r.old_weight));
    grow_calc = ((diff_calc > 0) && (prev > 0)) || ((diff_calc < 0) && (prev < 0));
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    red_nxt        = red_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    weight_nxt     = weight_r;
    first_nxt      = first_r;
    rate_sel_nxt   = rate_sel_r;
    factor_sel_nxt = factor_sel_r;
    diff_nxt       = diff_r;
    grow_nxt       = grow_r;
    out_valid_nxt  = 1'b0;
    out_rate_nxt   = out_rate_r;
    out_change_nxt = out_change_r;
    out_grew_nxt   = out_grew_r;
    mem_we         = 1'b0;
    mem_waddr      = idx;
    mem_wdata      = '0;
    rd_en          = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          red_nxt    = in_weight_index;
          weight_nxt = in_weight_value;
          first_nxt  = in_first_epoch;
          step_nxt   = STEP_W'(1);
          state_nxt  = NEED_MOD ? S_MOD : S_READ;
        end
      end
      S_MOD: begin
        // The first step forms the quotient by reciprocal multiplication, the second removes
        // that many multiples of NUM_WEIGHTS from the index.
        if (step_r == '0) begin
          red_nxt   = red_r - mod_sub[IN_IDX_W-1:0];
          state_nxt = S_READ;
        end else begin
          quo_nxt  = quo_prod[MOD_PROD_W-1:MOD_W];
          step_nxt = step_r - 1'b1;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        rate_sel_nxt   = rd_q_r.valid ? rd_q_r.rate : init_rate;
        factor_sel_nxt = grow_calc ? increase_r : decrease_r;
        diff_nxt       = diff_calc;
        grow_nxt       = grow_calc;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        mem_we                = 1'b1;
        mem_wdata.valid       = 1'b1;
        mem_wdata.old_weight  = weight_r;
        mem_wdata.prev_change = diff_r;
        mem_wdata.rate        = round_sat(product_r);
        out_valid_nxt         = 1'b1;
        out_rate_nxt          = round_sat(product_r);
        out_change_nxt        = diff_r;
        out_grew_nxt          = grow_r;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r        <= red_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    weight_r     <= weight_nxt;
    first_r      <= first_nxt;
    rate_sel_r   <= rate_sel_nxt;
    factor_sel_r <= factor_sel_nxt;
    diff_r       <= diff_nxt;
    grow_r       <= grow_nxt;
    product_r    <= product_nxt;
    out_rate_r   <= out_rate_nxt;
    out_change_r <= out_change_nxt;
    out_grew_r   <= out_grew_nxt;
  end

  // Only one transaction is in flight, so its read and its write-back never meet another.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem_r[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q_r <= entry_mem_r[idx];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_rate      = out_rate_r;
  assign out_weight_change = out_change_r;
  assign out_rate_grew     = out_grew_r;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the adaptive learning-rate block.
// A predictor in this module keeps its own copy of every per-weight entry and
// of the three rate registers. Each accepted input transaction is run through it
// at once, and the expected result is queued. A monitor compares every result
// strobe with the oldest queued result, field by field.

module tb_top;
  import arsu_pkg::*;

  localparam int unsigned NUM_W        = 1024;
  // The clearing pass after reset, one item and the longest sender gap all stay well below
  // STALL_LIMIT, so that many quiet cycles in a row mean a hang.
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned GAP_PERCENT  = 27;
  localparam longint      CHANGE_MAX   = 64'sd2147483647;
  localparam longint      CHANGE_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic [WORD_W-1:0] rate;
    logic [WORD_W-1:0] change;
    logic              grew;
  } rate_update_t;

  logic                        clk;
  logic                        rst_n             = 1'b0;
  logic                        start             = 1'b0;
  logic                        busy;
  logic [IN_IDX_W-1:0]         in_weight_index   = '0;
  logic signed [WORD_W-1:0]    in_weight_value   = '0;
  logic                        in_first_epoch    = 1'b0;
  logic                        out_valid;
  logic [WORD_W-1:0]           out_new_rate;
  logic signed [WORD_W-1:0]    out_weight_change;
  logic                        out_rate_grew;
  logic                        psel              = 1'b0;
  logic                        penable           = 1'b0;
  logic                        pwrite            = 1'b0;
  logic [CFG_ADDR_W-1:0]       paddr             = '0;
  logic [CFG_DATA_W-1:0]       pwdata            = '0;
  logic [CFG_DATA_W-1:0]       prdata;
  logic                        pready;

  // Predictor state. An entry counts as written once any transaction has updated it.
  // Because reset is applied only once, that is the same as the block's valid flag.
  logic [WORD_W-1:0]   model_old_weight  [NUM_W];
  logic [WORD_W-1:0]   model_prev_change [NUM_W];
  logic [WORD_W-1:0]   model_rate        [NUM_W];
  bit                  model_written     [NUM_W];
  logic [FACTOR_W-1:0] model_increase = INCREASE_RST;
  logic [FACTOR_W-1:0] model_decrease = DECREASE_RST;
  logic [WORD_W-1:0]   model_start    = START_RST;

  rate_update_t expected_updates[$];
  int unsigned  fail_count   = 0;
  int unsigned  quiet_cycles = 0;
  bit           gaps_on      = 1'b1;

  adaptive_rate_sign_update_top #(
    .NUM_WEIGHTS(NUM_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_weight_index  (in_weight_index),
    .in_weight_value  (in_weight_value),
    .in_first_epoch   (in_first_epoch),
    .out_valid        (out_valid),
    .out_new_rate     (out_new_rate),
    .out_weight_change(out_weight_change),
    .out_rate_grew    (out_rate_grew),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Only the first few failures are printed. The rest are just counted.
  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    end
  endfunction

  // Q8.24 rate times Q2.14 factor. Half an output LSB is added before the shift,
  // so the result rounds half up. Anything above 32 bits saturates to all ones.
  function automatic logic [WORD_W-1:0] scaled_rate(logic [WORD_W-1:0] rate,
                                                    logic [FACTOR_W-1:0] factor);
    logic [63:0] prod;
    prod = (64'(rate) * 64'(factor) + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
    return (prod > 64'hFFFF_FFFF) ? '1 : prod[WORD_W-1:0];
  endfunction

  // The weight difference is formed at full width and then clamped to signed 32 bits.
  function automatic logic [WORD_W-1:0] clamped_change(logic signed [WORD_W-1:0] now_w,
                                                       logic signed [WORD_W-1:0] old_w);
    longint diff;
    diff = longint'(now_w) - longint'(old_w);
    if (diff > CHANGE_MAX) begin
      diff = CHANGE_MAX;
    end
    if (diff < CHANGE_MIN) begin
      diff = CHANGE_MIN;
    end
    return WORD_W'(diff);
  endfunction

  // Updates the predicted entry for one accepted transaction and queues its result.
  function automatic void predict_update(logic [IN_IDX_W-1:0] idx, logic [WORD_W-1:0] value,
                                         logic first);
    int unsigned              slot;
    logic [WORD_W-1:0]        old_w;
    logic [WORD_W-1:0]        change;
    logic [WORD_W-1:0]        rate_in;
    logic [WORD_W-1:0]        rate_out;
    logic signed [WORD_W-1:0] prev;
    logic                     grew;
    slot   = int'(idx) % NUM_W;
    old_w  = first ? value : model_old_weight[slot];
    change = clamped_change(value, old_w);
    // An entry that was never written starts from start_rate already scaled up once,
    // and it has no previous change.
    if (model_written[slot]) begin
      prev    = model_prev_change[slot];
      rate_in = model_rate[slot];
    end else begin
      prev    = '0;
      rate_in = scaled_rate(model_start, model_increase);
    end
    // The rate grows only when both changes are strictly the same sign. A zero change shrinks it.
    grew     = ($signed(change) > 0 && prev > 0) || ($signed(change) < 0 && prev < 0);
    rate_out = scaled_rate(rate_in, grew ? model_increase : model_decrease);
    model_old_weight[slot]  = value;
    model_prev_change[slot] = change;
    model_rate[slot]        = rate_out;
    model_written[slot]     = 1'b1;
    expected_updates.push_back('{rate: rate_out, change: change, grew: grew});
  endfunction

  // Result monitor. Results cannot be stalled, so every strobe is one transaction.
  always @(posedge clk) begin
    rate_update_t want;
    if (rst_n && out_valid) begin
      if (expected_updates.size() == 0) begin
        note_failure($sformatf("unexpected result: rate %h change %h grew %b",
                               out_new_rate, out_weight_change, out_rate_grew));
      end else begin
        want = expected_updates.pop_front();
        check_field("new_rate", want.rate, out_new_rate);
        check_field("weight_change", want.change, out_weight_change);
        check_field("rate_grew", WORD_W'(want.grew), WORD_W'(out_rate_grew));
      end
    end
  end

  // The watchdog counts cycles with no transaction on any port. That covers a hang
  // anywhere, including a clearing pass that never ends.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drives one input transaction and holds it until the block accepts it.
  // In about a quarter of the calls start drops first for a random gap, and the
  // payload carries junk that the block has to ignore. Start stays high after
  // acceptance, so back-to-back items keep the request asserted.
  task automatic send_update(logic [IN_IDX_W-1:0] idx, logic [WORD_W-1:0] value,
                             logic first);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      gap = $urandom_range(8, 1);
    end
    @(negedge clk);
    if (gap > 0) begin
      start           <= 1'b0;
      in_weight_index <= IN_IDX_W'($urandom);
      in_weight_value <= $urandom;
      in_first_epoch  <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_weight_index <= idx;
    in_weight_value <= value;
    in_first_epoch  <= first;
    do @(posedge clk); while (busy);
    predict_update(idx, value, first);
  endtask

  // Drops the request and waits until every queued result has come back and the block is idle.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_updates.size() != 0 || busy) @(posedge clk);
  endtask

  // One register transaction: a setup phase, then an access phase that ends at a pready edge.
  // A write updates the predicted register. A read of a defined register is checked against it.
  task automatic apb_transfer(reg_idx_t which, logic wr, logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_ADDR_W'({which, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (which)
      REG_INCREASE: want = CFG_DATA_W'(model_increase);
      REG_DECREASE: want = CFG_DATA_W'(model_decrease);
      REG_START:    want = model_start;
      default:      want = '0;
    endcase
    if (wr) begin
      case (which)
        REG_INCREASE: model_increase = data[FACTOR_W-1:0];
        REG_DECREASE: model_decrease = data[FACTOR_W-1:0];
        REG_START:    model_start    = data;
        default:      ;
      endcase
    end else if (which != REG_NONE) begin
      check_field($sformatf("register %s read", which.name()), want, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes all three rate registers, then tries a write above the register map, which
  // must change nothing. Then it reads every register back. The upper half of each
  // factor write carries junk, which the register must drop.
  task automatic program_rates(logic [FACTOR_W-1:0] inc, logic [FACTOR_W-1:0] dec,
                               logic [WORD_W-1:0] rate0);
    apb_transfer(REG_INCREASE, 1'b1, {16'($urandom), inc});
    apb_transfer(REG_DECREASE, 1'b1, {16'($urandom), dec});
    apb_transfer(REG_START, 1'b1, rate0);
    apb_transfer(REG_NONE, 1'b1, $urandom);
    apb_transfer(REG_INCREASE, 1'b0, '0);
    apb_transfer(REG_DECREASE, 1'b0, '0);
    apb_transfer(REG_START, 1'b0, '0);
  endtask

  // Random epochs mostly inside a window of indices, so that each entry sees a run of
  // updates. An entry that was never written always gets a first-epoch update.
  // A written entry mostly gets small steps that tend to keep the sign of its last
  // change. Zero steps, full-range jumps, extreme weights and fresh first epochs are
  // mixed in.
  task automatic random_epochs(int unsigned count, int unsigned lo, int unsigned hi);
    int unsigned       idx;
    int unsigned       pick;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] delta;
    logic              first;
    repeat (count) begin
      idx = ($urandom_range(9) == 0) ? $urandom_range(NUM_W - 1) : $urandom_range(hi, lo);
      first = 1'b0;
      pick  = $urandom_range(99);
      if (!model_written[idx] || pick < 8) begin
        first = 1'b1;
        value = $urandom;
      end else if (pick < 18) begin
        value = model_old_weight[idx];
      end else if (pick < 68) begin
        delta = $urandom_range(4096, 1);
        if (($signed(model_prev_change[idx]) < 0) ^ ($urandom_range(99) < 35)) begin
          delta = -delta;
        end
        value = model_old_weight[idx] + delta;
      end else if (pick < 85) begin
        value = $urandom;
      end else begin
        value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      send_update(IN_IDX_W'(idx), value, first);
    end
    settle();
  endtask

  // The reset values of the registers are checked first. Then comes a write above the
  // map, which must leave them unchanged.
  task automatic test_register_access();
    apb_transfer(REG_INCREASE, 1'b0, '0);
    apb_transfer(REG_DECREASE, 1'b0, '0);
    apb_transfer(REG_START, 1'b0, '0);
    apb_transfer(REG_NONE, 1'b1, '1);
    apb_transfer(REG_INCREASE, 1'b0, '0);
    apb_transfer(REG_DECREASE, 1'b0, '0);
    apb_transfer(REG_START, 1'b0, '0);
  endtask

  // Hand-picked epochs under the reset register values. They cover fresh entries,
  // the lowest and highest index, saturation of the change in both directions, the
  // exact negative limit without saturation, growth on agreeing signs, shrinking on
  // a sign flip and on a zero change, and a new first epoch on an entry that is
  // already valid.
  task automatic test_directed_epochs();
    send_update(10'd0, 32'h0000_0000, 1'b1);
    send_update(10'd1023, 32'h7FFF_FFFF, 1'b1);
    send_update(10'd1023, 32'h8000_0000, 1'b0);
    send_update(10'd1023, 32'h7FFF_FFFF, 1'b0);
    send_update(10'd1023, 32'h7FFF_FFFF, 1'b0);
    send_update(10'd5, 32'd100, 1'b1);
    send_update(10'd5, 32'd200, 1'b0);
    send_update(10'd5, 32'd300, 1'b0);
    send_update(10'd5, 32'd250, 1'b0);
    send_update(10'd5, 32'd200, 1'b0);
    send_update(10'd5, 32'd777, 1'b1);
    send_update(10'd2, 32'hFFFF_FFFF, 1'b1);
    send_update(10'd2, 32'h8000_0000, 1'b0);
    send_update(10'd2, 32'h7FFF_FFFF, 1'b0);
    send_update(10'd2, 32'hFFFF_FFFF, 1'b0);
    send_update(10'd512, 32'd0, 1'b1);
    send_update(10'd512, 32'd1, 1'b0);
    send_update(10'd512, 32'd2, 1'b0);
    send_update(10'd512, 32'd1, 1'b0);
    send_update(10'd341, 32'h5555_5555, 1'b1);
    send_update(10'd682, 32'hAAAA_AAAA, 1'b1);
    settle();
  endtask

  // The register extremes run mostly on indices of their own near the top of the table, so
  // that rates stuck at zero or at saturation mostly stay out of the random traffic.
  task automatic test_config_extremes();
    program_rates(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    random_epochs(30, 900, 931);
    program_rates(16'h0000, 16'h0000, 32'h0000_0000);
    random_epochs(30, 932, 963);
    program_rates(16'hFFFF, 16'h0000, 32'h0000_0001);
    random_epochs(30, 964, 995);
    program_rates(16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    random_epochs(30, 996, 1022);
  endtask

  // Random traffic in several phases, with fresh register values before each phase.
  // Most phases use factors near the usual growth and decay. One phase uses fully
  // random values. One runs with no sender gaps at all.
  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < 7; phase++) begin
      if (phase == 5) begin
        program_rates(16'($urandom), 16'($urandom), $urandom);
      end else begin
        program_rates(16'($urandom_range(22000, 16384)), 16'($urandom_range(16384, 6000)),
                      $urandom_range(32'h0400_0000, 1));
      end
      gaps_on = (phase != 3);
      random_epochs(260, phase * 110, phase * 110 + 63);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_directed_epochs();
    test_config_extremes();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_updates.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_updates.size()));
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
